FILE: hw/rtl/tnmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tnmt_pkg: shared types and constants of the tanh neuron trainer
// Widths, request and result codes, register indexes, the state encoding
// and the tanh table built at elaboration.
// ----------------------------------------------------------------------------
package tnmt_pkg;

  // data widths
  localparam int ValW     = 16;                      // Q3.12 values
  localparam int FracW    = 12;
  localparam int MaxInputs = 64;
  localparam int IdxW     = $clog2(MaxInputs);       // input store address
  localparam int SlotW    = $clog2(MaxInputs + 1);   // weight slot incl. bias
  localparam int CntW     = 7;                       // input_count register
  localparam int ReqW     = 2;
  localparam int OutW     = 14;
  localparam int AccW     = 40;
  localparam int CfgW     = 16;
  localparam int CfgIdxW  = 2;
  localparam int MulAW    = ValW + 1;
  localparam int MulPW    = MulAW + ValW;
  localparam int GainShift = 16;
  localparam int TabShift = 6;
  localparam int TabLen   = 513;
  localparam int TabIdxW  = $clog2(TabLen);
  localparam int TabW     = 13;

  localparam logic [SlotW-1:0]        BiasSlot = SlotW'(MaxInputs);
  localparam logic signed [ValW-1:0]  OneQ12   = ValW'(1 << FracW);

  // request codes
  typedef enum logic [ReqW-1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_TRAIN  = 2'd1,
    REQ_LOAD   = 2'd2
  } req_e;

  // result codes
  typedef enum logic {
    RES_ACT   = 1'b0,
    RES_TRAIN = 1'b1
  } res_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_INPUT_COUNT   = 2'd0,
    CFG_LEARN_RATE    = 2'd1,
    CFG_MOMENTUM_GAIN = 2'd2
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMP_MUL,
    ST_SMP_ACC,
    ST_SMP_BIAS,
    ST_SMP_TAB,
    ST_SMP_OUT,
    ST_TRN_GAIN,
    ST_TRN_MX,
    ST_TRN_MD,
    ST_TRN_DLT,
    ST_TRN_WGT,
    ST_TRN_OUT
  } state_e;

  typedef logic [TabW-1:0] tanh_tab_t [TabLen];

  // saturate to the value width
  function automatic logic signed [ValW-1:0] sat_val(input logic signed [31:0] v);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = 32'sd1 <<< (ValW - 1);
    hi = hi - 32'sd1;
    lo = -hi - 32'sd1;
    if (v > hi) begin
      return ValW'(hi);
    end else if (v < lo) begin
      return ValW'(lo);
    end
    return ValW'(v);
  endfunction

  // restoring division, elaboration use only; quotient below 2**qbits
  function automatic logic [63:0] udiv(input logic [127:0] num, input logic [63:0] den,
                                       input int qbits);
    logic [127:0] rem;
    logic [127:0] dsh;
    logic [63:0]  q;
    rem = num;
    q   = '0;
    for (int b = qbits - 1; b >= 0; b--) begin
      dsh = {64'b0, den} << b;
      if (rem >= dsh) begin
        rem  = rem - dsh;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // entry k = round(4096 * tanh(k/64)) from t = exp(-k/32) in Q50
  function automatic tanh_tab_t build_tanh_tab();
    logic [63:0]  fx_one;
    logic [63:0]  r;
    logic [63:0]  term;
    logic [63:0]  t;
    logic [63:0]  q;
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] prod;
    tanh_tab_t    tab;
    fx_one = 64'd1 << 50;
    r      = fx_one;
    term   = fx_one;
    t      = fx_one;
    // exp(-1/32) by its series
    for (int n = 1; n <= 14; n++) begin
      term = udiv({64'b0, term >> 5}, 64'(n), 51);
      if ((n % 2) == 1) begin
        r = r - term;
      end else begin
        r = r + term;
      end
    end
    for (int k = 0; k < TabLen; k++) begin
      num    = {64'b0, fx_one - t} * 128'd4096;
      den    = {64'b0, fx_one + t};
      q      = udiv((num << 1) + den, den[62:0] << 1, TabW);
      tab[k] = q[TabW-1:0];
      prod   = {64'b0, t} * {64'b0, r};
      t      = prod[113:50];
    end
    return tab;
  endfunction

  localparam tanh_tab_t TanhTab = build_tanh_tab();

endpackage : tnmt_pkg
`default_nettype wire

FILE: hw/rtl/tnmt_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tnmt_req_if: request channel
// Valid/ready channel carrying one sample, train or weight load request.
// ----------------------------------------------------------------------------
interface tnmt_req_if import tnmt_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [ReqW-1:0]          req_type;
  logic signed [ValW-1:0]   sample;
  logic signed [ValW-1:0]   sigma;
  logic [SlotW-1:0]         weight_index;
  logic signed [ValW-1:0]   weight_value;

  modport source (output valid, req_type, sample, sigma, weight_index, weight_value,
                  input ready);
  modport sink   (input valid, req_type, sample, sigma, weight_index, weight_value,
                  output ready);
endinterface : tnmt_req_if
`default_nettype wire

FILE: hw/rtl/tnmt_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tnmt_rsp_if: result channel
// Valid/ready channel carrying an activation or a training-done result.
// ----------------------------------------------------------------------------
interface tnmt_rsp_if import tnmt_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     result_kind;
  logic signed [OutW-1:0]   value;

  modport source (output valid, result_kind, value, input ready);
  modport sink   (input valid, result_kind, value, output ready);
endinterface : tnmt_rsp_if
`default_nettype wire

FILE: hw/rtl/tanh_neuron_momentum_train_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tanh_neuron_momentum_train_top: tanh neuron with momentum training
// Stores samples, multiply-accumulates them with the weights, applies the
// tanh table, and on request trains all weights in use and the bias.
//
//   port      dir   handshake       payload
//   req       in    valid/ready     req_type sample sigma weight_index weight_value
//   rsp       out   valid/ready     result_kind value
//   cfg_*_i   in    write enable    register index, write data
//
// A sample runs SMP_MUL and SMP_ACC, the last of a vector then SMP_BIAS,
// SMP_TAB and SMP_OUT, which waits for the result register. A train runs
// TRN_GAIN, then TRN_MX, TRN_MD, TRN_DLT and TRN_WGT for each slot in use
// and the bias, then TRN_OUT: each slot runs two multiplies on the one
// shared multiplier and a read-modify-write of the weight and delta RAMs.
// Reset clears the sequencer, the counter, the accumulator and the delta
// valid bits; deltas read as zero until written, no clearing pass.
// req.ready is high only while the sequencer is idle; a held result does
// not block new requests until another result is due.
// ----------------------------------------------------------------------------
module tanh_neuron_momentum_train_top import tnmt_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  tnmt_req_if.sink                req,
  tnmt_rsp_if.source              rsp
);

  // configuration registers
  logic [CntW-1:0]  input_count_q;
  logic [CfgW-1:0]  learn_rate_q;
  logic [CfgW-1:0]  momentum_gain_q;

  // control state
  state_e                 state_q, state_d;
  logic [IdxW-1:0]        ctr_q;
  logic signed [AccW-1:0] acc_q;
  logic [SlotW-1:0]       slot_q;
  logic [MaxInputs:0]     dval_q;
  logic                   out_valid_q;

  // payload registers
  logic signed [ValW-1:0]       x_q;
  logic signed [ValW-1:0]       g_q;
  logic signed [MulPW-FracW-1:0] t1_q;
  logic signed [ValW-1:0]       dnew_q;
  logic signed [ValW-1:0]       s_q;
  logic [TabW-1:0]              tab_q;
  logic                         neg_q;
  logic                         out_kind_q;
  logic signed [OutW-1:0]       out_val_q;

  // RAM ports
  logic                   w_we, w_re;
  logic [SlotW-1:0]       w_waddr, w_raddr;
  logic signed [ValW-1:0] w_wdata, w_rdata;
  logic                   i_we, i_re;
  logic [IdxW-1:0]        i_waddr, i_raddr;
  logic signed [ValW-1:0] i_rdata;
  logic                   d_we, d_re;
  logic [SlotW-1:0]       d_raddr;
  logic signed [ValW-1:0] d_rdata;

  // multiplier
  logic                    mul_en;
  logic signed [MulAW-1:0] mul_a;
  logic signed [ValW-1:0]  mul_b;
  logic signed [MulPW-1:0] mul_p;

  // misc
  logic                   req_fire;
  logic                   out_free;
  logic                   out_load;
  logic [CntW-1:0]        cnt;
  logic [CntW-1:0]        ctr_inc;
  logic                   smp_last;
  logic                   slot_bias;
  logic [SlotW-1:0]       slot_nxt;
  logic signed [ValW-1:0] x_eff;
  logic signed [ValW-1:0] d_eff;
  logic signed [ValW-1:0] bias_sum;
  logic signed [ValW-1:0] dlt_sum;
  logic signed [ValW-1:0] wgt_sum;
  logic signed [ValW-TabShift-1:0] tab_n;
  logic [TabIdxW-1:0]     tab_idx;

  assign req_fire  = req.valid && req.ready;
  assign req.ready = (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || rsp.ready;

  // inputs in use, out-of-range counts clamped
  always_comb begin
    if (input_count_q == '0) begin
      cnt = CntW'(1);
    end else if (input_count_q > CntW'(MaxInputs)) begin
      cnt = CntW'(MaxInputs);
    end else begin
      cnt = input_count_q;
    end
  end

  assign ctr_inc   = CntW'(ctr_q) + CntW'(1);
  assign smp_last  = (ctr_inc >= cnt);
  assign slot_bias = (slot_q == BiasSlot);
  assign slot_nxt  = (slot_q == SlotW'(cnt - CntW'(1))) ? BiasSlot : slot_q + SlotW'(1);
  assign x_eff     = slot_bias ? OneQ12 : i_rdata;
  assign d_eff     = dval_q[slot_q] ? d_rdata : '0;

  // bias add and saturate, then table index from the magnitude
  assign bias_sum = sat_val(32'($signed(acc_q[AccW-1:FracW])) + 32'(w_rdata));
  assign tab_n    = s_q[ValW-1:TabShift];
  assign tab_idx  = tab_n[ValW-TabShift-1] ? TabIdxW'(-tab_n) : TabIdxW'(tab_n);

  // delta and weight update
  assign dlt_sum = sat_val(32'(t1_q) + 32'($signed(mul_p[MulPW-1:GainShift])));
  assign wgt_sum = sat_val(32'(w_rdata) + 32'(dnew_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          case (req.req_type)
            REQ_SAMPLE: state_d = ST_SMP_MUL;
            REQ_TRAIN:  state_d = ST_TRN_GAIN;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_SMP_MUL:  state_d = ST_SMP_ACC;
      ST_SMP_ACC:  state_d = smp_last ? ST_SMP_BIAS : ST_IDLE;
      ST_SMP_BIAS: state_d = ST_SMP_TAB;
      ST_SMP_TAB:  state_d = ST_SMP_OUT;
      ST_SMP_OUT:  state_d = out_free ? ST_IDLE : ST_SMP_OUT;
      ST_TRN_GAIN: state_d = ST_TRN_MX;
      ST_TRN_MX:   state_d = ST_TRN_MD;
      ST_TRN_MD:   state_d = ST_TRN_DLT;
      ST_TRN_DLT:  state_d = ST_TRN_WGT;
      ST_TRN_WGT:  state_d = slot_bias ? ST_TRN_OUT : ST_TRN_MX;
      ST_TRN_OUT:  state_d = out_free ? ST_IDLE : ST_TRN_OUT;
      default:     state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: RAM ports, multiplier operands, result load
  always_comb begin
    w_we     = 1'b0;
    w_waddr  = req.weight_index;
    w_wdata  = req.weight_value;
    w_re     = 1'b0;
    w_raddr  = SlotW'(ctr_q);
    i_we     = 1'b0;
    i_waddr  = ctr_q;
    i_re     = 1'b0;
    i_raddr  = slot_q[IdxW-1:0];
    d_we     = 1'b0;
    d_re     = 1'b0;
    d_raddr  = slot_q;
    mul_en   = 1'b0;
    mul_a    = MulAW'({1'b0, learn_rate_q});
    mul_b    = req.sigma;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          case (req.req_type)
            REQ_SAMPLE: begin
              w_re = 1'b1;
              i_we = 1'b1;
            end
            REQ_TRAIN: begin
              mul_en = 1'b1;
            end
            REQ_LOAD: begin
              w_we = (req.weight_index <= BiasSlot);
            end
            default: ;
          endcase
        end
      end
      ST_SMP_MUL: begin
        mul_en = 1'b1;
        mul_a  = MulAW'(w_rdata);
        mul_b  = x_q;
      end
      ST_SMP_ACC: begin
        w_re    = smp_last;
        w_raddr = BiasSlot;
      end
      ST_SMP_OUT: begin
        out_load = out_free;
      end
      ST_TRN_GAIN: begin
        w_re    = 1'b1;
        i_re    = 1'b1;
        d_re    = 1'b1;
        w_raddr = slot_q;
      end
      ST_TRN_MX: begin
        mul_en = 1'b1;
        mul_a  = MulAW'(g_q);
        mul_b  = x_eff;
      end
      ST_TRN_MD: begin
        mul_en = 1'b1;
        mul_a  = MulAW'({1'b0, momentum_gain_q});
        mul_b  = d_eff;
      end
      ST_TRN_DLT: begin
        d_we = 1'b1;
      end
      ST_TRN_WGT: begin
        w_we    = 1'b1;
        w_waddr = slot_q;
        w_wdata = wgt_sum;
        // prefetch the next slot
        w_re    = !slot_bias;
        i_re    = !slot_bias;
        d_re    = !slot_bias;
        w_raddr = slot_nxt;
        i_raddr = slot_nxt[IdxW-1:0];
        d_raddr = slot_nxt;
      end
      ST_TRN_OUT: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      input_count_q   <= CntW'(MaxInputs);
      learn_rate_q    <= CfgW'(6554);
      momentum_gain_q <= CfgW'(6554);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INPUT_COUNT:   input_count_q   <= cfg_wdata_i[CntW-1:0];
        CFG_LEARN_RATE:    learn_rate_q    <= cfg_wdata_i;
        CFG_MOMENTUM_GAIN: momentum_gain_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ctr_q       <= '0;
      acc_q       <= '0;
      slot_q      <= '0;
      dval_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (req_fire && req.req_type == REQ_TRAIN) begin
        slot_q <= '0;
      end else if (state_q == ST_TRN_WGT && !slot_bias) begin
        slot_q <= slot_nxt;
      end
      if (state_q == ST_SMP_ACC) begin
        acc_q <= acc_q + AccW'(mul_p);
        ctr_q <= smp_last ? '0 : ctr_inc[IdxW-1:0];
      end else if (state_q == ST_SMP_BIAS) begin
        acc_q <= '0;
      end
      if (d_we) begin
        dval_q[slot_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      x_q <= req.sample;
    end
    if (state_q == ST_TRN_GAIN) begin
      g_q <= mul_p[GainShift+ValW-1:GainShift];
    end
    if (state_q == ST_TRN_MD) begin
      t1_q <= mul_p[MulPW-1:FracW];
    end
    if (state_q == ST_TRN_DLT) begin
      dnew_q <= dlt_sum;
    end
    if (state_q == ST_SMP_BIAS) begin
      s_q <= bias_sum;
    end
    if (state_q == ST_SMP_TAB) begin
      tab_q <= TanhTab[tab_idx];
      neg_q <= tab_n[ValW-TabShift-1];
    end
    if (out_load) begin
      if (state_q == ST_TRN_OUT) begin
        out_kind_q <= RES_TRAIN;
        out_val_q  <= '0;
      end else begin
        out_kind_q <= RES_ACT;
        out_val_q  <= neg_q ? -OutW'({1'b0, tab_q}) : OutW'({1'b0, tab_q});
      end
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.result_kind = out_kind_q;
  assign rsp.value       = out_val_q;

  // weight store, bias in the last slot
  tnmt_ram #(
    .Width (ValW),
    .Depth (MaxInputs + 1)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .re_i    (w_re),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  // stored samples
  tnmt_ram #(
    .Width (ValW),
    .Depth (MaxInputs)
  ) u_input_ram (
    .clk_i   (clk_i),
    .we_i    (i_we),
    .waddr_i (i_waddr),
    .wdata_i (req.sample),
    .re_i    (i_re),
    .raddr_i (i_raddr),
    .rdata_o (i_rdata)
  );

  // momentum deltas, unwritten entries read as zero via dval_q
  tnmt_ram #(
    .Width (ValW),
    .Depth (MaxInputs + 1)
  ) u_delta_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (slot_q),
    .wdata_i (dlt_sum),
    .re_i    (d_re),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  // shared multiplier
  tnmt_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // training walk stays within the inputs in use or the bias
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TRN_MX) |-> (slot_bias || (CntW'(slot_q) < cnt)))
    else $error("train slot out of range");

  // bias delta is written before training reports done
  a_bias_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TRN_OUT) |-> dval_q[BiasSlot])
    else $error("train done before bias update");

  // vector state is cleared once the activation is on its way
  a_vec_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SMP_TAB) |-> (acc_q == '0 && ctr_q == '0))
    else $error("accumulator or counter not cleared");

  // activation stays within plus and minus one
  a_val_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> (rsp.value <= 14'sd4096 && rsp.value >= -14'sd4096))
    else $error("activation out of range");

  // training result carries a zero value
  a_train_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.result_kind == RES_TRAIN) |-> (rsp.value == '0))
    else $error("training result with nonzero value");

endmodule : tanh_neuron_momentum_train_top
`default_nettype wire

FILE: hw/rtl/tnmt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tnmt_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tnmt_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : tnmt_ram
`default_nettype wire

FILE: hw/rtl/tnmt_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tnmt_mul: shared signed multiplier
// One signed multiply per enabled cycle, product registered.
// ----------------------------------------------------------------------------
module tnmt_mul import tnmt_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic signed [MulAW-1:0]  a_i,
  input  wire logic signed [ValW-1:0]   b_i,
  output logic signed      [MulPW-1:0]  p_o
);

  logic signed [MulPW-1:0] p_q;
  logic signed [MulPW-1:0] a_ext;
  logic signed [MulPW-1:0] b_ext;

  assign a_ext = MulPW'(a_i);
  assign b_ext = MulPW'(b_i);

  // product register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_ext * b_ext;
    end
  end

  assign p_o = p_q;

endmodule : tnmt_mul
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: tanh neuron trainer, self-checking random test
// Drives sample, train and weight load transactions with bursty timing,
// stalls the result channel, and compares every result against a
// bit-accurate neuron predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
import tnmt_pkg::*;

// one request transaction
typedef struct {
  logic [ReqW-1:0]        kind;
  logic signed [ValW-1:0] sample;
  logic signed [ValW-1:0] sigma;
  logic [SlotW-1:0]       widx;
  logic signed [ValW-1:0] wval;
} neuron_req_t;

// one result transaction
typedef struct {
  logic                   kind;
  logic signed [OutW-1:0] value;
} neuron_rsp_t;

// neuron predictor and queue of expected results
class neuron_scoreboard;
  longint                 weight_mem[MaxInputs+1];
  longint                 delta_mem[MaxInputs+1];
  longint                 input_mem[MaxInputs];
  logic [MaxInputs-1:0]   inputs_seen;
  int unsigned            sample_cnt;
  logic [AccW-1:0]        acc;
  logic [CntW-1:0]        input_count;
  logic [CfgW-1:0]        learn_rate;
  logic [CfgW-1:0]        momentum_gain;
  int                     tanh_lut[TabLen];
  neuron_rsp_t            expected_q[$];
  int unsigned            mismatches;

  function new();
    logic [63:0]  one_fx;
    logic [63:0]  rate;
    logic [63:0]  term;
    logic [63:0]  t;
    logic [63:0]  num;
    logic [63:0]  den;
    logic [127:0] prod;
    // exp(-1/32) in Q50 from its series, then t = exp(-k/32) per entry
    one_fx = 64'd1 << 50;
    rate   = one_fx;
    term   = one_fx;
    t      = one_fx;
    for (int n = 1; n <= 14; n++) begin
      term = term / (64'd32 * 64'(n));
      if ((n % 2) == 1) begin
        rate = rate - term;
      end else begin
        rate = rate + term;
      end
    end
    for (int k = 0; k < TabLen; k++) begin
      num         = (one_fx - t) * 64'd4096;
      den         = one_fx + t;
      tanh_lut[k] = int'((2 * num + den) / (2 * den));
      prod        = {64'd0, t} * {64'd0, rate};
      t           = prod[113:50];
    end
    // state after reset
    foreach (weight_mem[i]) weight_mem[i] = 0;
    foreach (delta_mem[i]) delta_mem[i] = 0;
    foreach (input_mem[i]) input_mem[i] = 0;
    inputs_seen   = '0;
    sample_cnt    = 0;
    acc           = '0;
    input_count   = CntW'(MaxInputs);
    learn_rate    = 16'd6554;
    momentum_gain = 16'd6554;
    mismatches    = 0;
  endfunction

  function int unsigned active_inputs();
    if (input_count == 0) return 1;
    if (input_count > MaxInputs) return MaxInputs;
    return input_count;
  endfunction

  function longint sat_q12(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // momentum update of one weight slot
  function void train_slot(int unsigned slot, longint g, longint x);
    longint d;
    d = sat_q12(((g * x) >>> FracW) +
                ((longint'(momentum_gain) * delta_mem[slot]) >>> GainShift));
    delta_mem[slot]  = d;
    weight_mem[slot] = sat_q12(weight_mem[slot] + d);
  endfunction

  function void write_reg(cfg_idx_e idx, logic [CfgW-1:0] data);
    case (idx)
      CFG_INPUT_COUNT:   input_count   = data[CntW-1:0];
      CFG_LEARN_RATE:    learn_rate    = data;
      CFG_MOMENTUM_GAIN: momentum_gain = data;
      default: ;
    endcase
  endfunction

  // accepted request: update the state, queue any result it causes
  function void note_request(neuron_req_t r);
    int unsigned cnt;
    int unsigned idx;
    longint      x;
    longint      g;
    longint      s_acc;
    longint      s;
    longint      n;
    longint      y;
    neuron_rsp_t res;
    cnt = active_inputs();
    case (r.kind)
      REQ_SAMPLE: begin
        idx = (sample_cnt < MaxInputs) ? sample_cnt : 0;
        x   = r.sample;
        input_mem[idx]   = x;
        inputs_seen[idx] = 1'b1;
        acc        = acc + AccW'(weight_mem[idx] * x);
        sample_cnt = idx + 1;
        if (sample_cnt >= cnt) begin
          s_acc = $signed(acc);
          s     = sat_q12((s_acc >>> FracW) + weight_mem[MaxInputs]);
          n     = s >>> TabShift;
          if (n > TabLen - 1) n = TabLen - 1;
          if (n < -(TabLen - 1)) n = -(TabLen - 1);
          y = (n < 0) ? -longint'(tanh_lut[-n]) : longint'(tanh_lut[n]);
          res.kind  = RES_ACT;
          res.value = OutW'(y);
          expected_q.push_back(res);
          sample_cnt = 0;
          acc        = '0;
        end
      end
      REQ_TRAIN: begin
        g = (longint'(learn_rate) * longint'(r.sigma)) >>> GainShift;
        for (int unsigned i = 0; i < cnt; i++) train_slot(i, g, input_mem[i]);
        train_slot(MaxInputs, g, longint'(OneQ12));
        res.kind  = RES_TRAIN;
        res.value = '0;
        expected_q.push_back(res);
      end
      REQ_LOAD: begin
        if (r.widx <= MaxInputs) weight_mem[r.widx] = r.wval;
      end
      default: ;
    endcase
  endfunction

  // accepted result: compare with the oldest expectation
  function void check_result(neuron_rsp_t got);
    neuron_rsp_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: kind %0d value %0d", got.kind, got.value);
      return;
    end
    want = expected_q.pop_front();
    if (got.kind !== want.kind || got.value !== want.value) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: kind exp %0d got %0d, value exp %0d got %0d",
                 want.kind, got.kind, want.value, got.value);
    end
  endfunction
endclass

module testbench;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned NumPhases  = 12;
  localparam int unsigned PhaseItems = 165;
  localparam int unsigned Settle     = 16;    // longest busy time without a result
  localparam int unsigned EndDrain   = 400;   // beyond a full-width train
  localparam logic [ReqW-1:0]       ReqUnused = 2'd3;   // no operation, ignored
  localparam logic signed [ValW-1:0] QMax     = 16'sh7FFF;
  localparam logic signed [ValW-1:0] QMin     = 16'sh8000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;
  logic               rsp_ready_q = 1'b0;
  int unsigned        stall_timer = 0;
  int unsigned        stall_mode  = 0;
  int unsigned        cycle_cnt   = 0;
  int unsigned        burst_left  = 0;

  tnmt_req_if req_if ();
  tnmt_rsp_if rsp_if ();

  neuron_scoreboard sb = new();

  tanh_neuron_momentum_train_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_if),
    .rsp         (rsp_if)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  assign rsp_if.ready = rsp_ready_q;

  // result stalls, the pattern and how long it holds are drawn at random
  always @(posedge clk_i) begin
    if (stall_timer == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      stall_timer <= $urandom_range(50, 400);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      0:       rsp_ready_q <= 1'b1;
      1:       rsp_ready_q <= 1'($urandom_range(0, 1));
      2:       rsp_ready_q <= ($urandom_range(0, 7) == 0);
      default: rsp_ready_q <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // result monitor
  always @(posedge clk_i) begin : result_mon
    neuron_rsp_t got;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got.kind  = rsp_if.result_kind;
      got.value = rsp_if.value;
      sb.check_result(got);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // mostly values within +-1.0, some extremes and some full range
  function automatic logic signed [ValW-1:0] rand_q12();
    int t;
    case ($urandom_range(0, 9))
      0:       return QMax;
      1:       return QMin;
      2:       return '0;
      3, 4:    return ValW'($urandom);
      default: begin
        t = int'($urandom_range(0, 8192)) - 4096;
        return ValW'(t);
      end
    endcase
  endfunction

  function automatic neuron_req_t mk(input logic [ReqW-1:0] k, input int smp, input int sig,
                                     input int wi, input int wv);
    neuron_req_t it;
    it.kind   = k;
    it.sample = ValW'(smp);
    it.sigma  = ValW'(sig);
    it.widx   = SlotW'(wi);
    it.wval   = ValW'(wv);
    return it;
  endfunction

  // mostly samples, trains only once every input in use holds a value
  function automatic neuron_req_t random_item();
    neuron_req_t          it;
    int unsigned          pick;
    logic [MaxInputs-1:0] need;
    it.kind   = REQ_SAMPLE;
    it.sample = rand_q12();
    it.sigma  = rand_q12();
    it.widx   = SlotW'($urandom_range(0, MaxInputs));
    it.wval   = rand_q12();
    need = {MaxInputs{1'b1}} >> (MaxInputs - sb.active_inputs());
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      if ((sb.inputs_seen & need) == need) it.kind = REQ_TRAIN;
    end else if (pick < 25) begin
      it.kind = REQ_LOAD;
      if ($urandom_range(0, 9) == 0) it.widx = SlotW'($urandom_range(MaxInputs + 1, 127));
    end else if (pick < 29) begin
      it.kind = ReqUnused;
    end
    return it;
  endfunction

  // present one transaction and wait until it is taken
  task automatic send_item(input neuron_req_t it);
    req_if.valid        <= 1'b1;
    req_if.req_type     <= it.kind;
    req_if.sample       <= it.sample;
    req_if.sigma        <= it.sigma;
    req_if.weight_index <= it.widx;
    req_if.weight_value <= it.wval;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    sb.note_request(it);
  endtask

  // bursts of random length separated by random gaps
  task automatic push_item(input neuron_req_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    send_item(it);
  endtask

  // drain all results, then let trailing work finish
  task automatic wait_idle(input int unsigned settle);
    req_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [CfgW-1:0] cnt_val, input logic [CfgW-1:0] lr_val,
                          input logic [CfgW-1:0] mg_val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_INPUT_COUNT;
    cfg_wdata_i <= cnt_val;
    @(posedge clk_i);
    sb.write_reg(CFG_INPUT_COUNT, cnt_val);
    cfg_idx_i   <= CFG_LEARN_RATE;
    cfg_wdata_i <= lr_val;
    @(posedge clk_i);
    sb.write_reg(CFG_LEARN_RATE, lr_val);
    cfg_idx_i   <= CFG_MOMENTUM_GAIN;
    cfg_wdata_i <= mg_val;
    @(posedge clk_i);
    sb.write_reg(CFG_MOMENTUM_GAIN, mg_val);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CntW-1:0] cnt_sel;
    logic [CfgW-1:0] lr_sel;
    logic [CfgW-1:0] mg_sel;
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CFG_INPUT_COUNT;
    cfg_wdata_i         <= '0;
    req_if.valid        <= 1'b0;
    req_if.req_type     <= REQ_SAMPLE;
    req_if.sample       <= '0;
    req_if.sigma        <= '0;
    req_if.weight_index <= '0;
    req_if.weight_value <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // fill: every weight and the bias, then one full vector and a train
    // under the reset register values
    for (int i = 0; i <= MaxInputs; i++) push_item(mk(REQ_LOAD, 0, 0, i, rand_q12()));
    for (int i = 0; i < MaxInputs; i++) push_item(mk(REQ_SAMPLE, rand_q12(), 0, 0, 0));
    push_item(mk(REQ_TRAIN, 0, rand_q12(), 0, 0));
    wait_idle(Settle);

    // directed: extreme values, full gains, saturated bias, ignored items
    set_regs(16'd2, 16'hFFFF, 16'hFFFF);
    send_item(mk(REQ_LOAD, 0, 0, 0, QMax));
    send_item(mk(REQ_LOAD, 0, 0, 1, QMin));
    send_item(mk(REQ_LOAD, 0, 0, MaxInputs, 0));
    send_item(mk(REQ_SAMPLE, QMax, 0, 0, 0));
    send_item(mk(REQ_SAMPLE, QMax, 0, 0, 0));
    send_item(mk(REQ_SAMPLE, QMin, 0, 0, 0));
    send_item(mk(REQ_SAMPLE, QMin, 0, 0, 0));
    send_item(mk(REQ_TRAIN, 0, QMax, 0, 0));
    send_item(mk(REQ_TRAIN, 0, QMin, 0, 0));
    send_item(mk(REQ_TRAIN, 0, 0, 0, 0));
    send_item(mk(REQ_LOAD, 0, 0, MaxInputs, QMax));
    send_item(mk(REQ_SAMPLE, 0, 0, 0, 0));
    send_item(mk(REQ_SAMPLE, 0, 0, 0, 0));
    send_item(mk(REQ_LOAD, 0, 0, MaxInputs, QMin));
    send_item(mk(REQ_SAMPLE, 4096, 0, 0, 0));
    send_item(mk(REQ_SAMPLE, -4096, 0, 0, 0));
    // loads past the bias slot and the unused code change nothing
    send_item(mk(REQ_LOAD, 0, 0, MaxInputs + 1, QMax));
    send_item(mk(REQ_LOAD, 0, 0, 127, QMin));
    send_item(mk(ReqUnused, QMax, QMin, 127, QMax));
    // count lowered mid-vector: the next sample completes it
    send_item(mk(REQ_SAMPLE, 100, 0, 0, 0));
    wait_idle(Settle);
    set_regs(16'd1, 16'hFFFF, 16'hFFFF);
    send_item(mk(REQ_SAMPLE, 200, 0, 0, 0));
    wait_idle(Settle);

    // random phases, each under its own register setting
    for (int unsigned p = 0; p < NumPhases; p++) begin
      case (p % 6)
        0:       cnt_sel = CntW'(MaxInputs);
        1:       cnt_sel = 7'd1;
        2:       cnt_sel = 7'd0;
        3:       cnt_sel = ($urandom_range(0, 1) == 0) ? 7'd100 : 7'd127;
        4:       cnt_sel = CntW'($urandom_range(2, 8));
        default: cnt_sel = CntW'($urandom_range(9, MaxInputs - 1));
      endcase
      case (p % 4)
        0:       lr_sel = 16'hFFFF;
        1:       lr_sel = 16'h0000;
        2:       lr_sel = 16'd6554;
        default: lr_sel = CfgW'($urandom);
      endcase
      case (p % 3)
        0:       mg_sel = 16'hFFFF;
        1:       mg_sel = 16'h0000;
        default: mg_sel = CfgW'($urandom);
      endcase
      // upper data bits of the count register are don't-care
      set_regs({(CfgW - CntW)'($urandom), cnt_sel}, lr_sel, mg_sel);
      for (int unsigned i = 0; i < PhaseItems; i++) push_item(random_item());
      wait_idle(Settle);
    end

    wait_idle(EndDrain);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule : testbench

FILE: files.f
hw/rtl/tnmt_pkg.sv
hw/rtl/tnmt_req_if.sv
hw/rtl/tnmt_rsp_if.sv
hw/rtl/tnmt_ram.sv
hw/rtl/tnmt_mul.sv
hw/rtl/tanh_neuron_momentum_train_top.sv
dv/testbench.sv
